[rtl/ecbs_pkg.sv]
// ----------------------------------------------------------------------------
// ecbs_pkg
// Shared types and constants for the error code blink sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package ecbs_pkg;

    // Field widths
    localparam int CODE_W   = 8;
    localparam int TICKS_W  = 16;
    localparam int BLINKS_W = 5;
    localparam int TENS_W   = 5;
    localparam int UNITS_W  = 4;
    localparam int CFG_IDX_W = 2;
    localparam int TDATA_W  = 8;

    // Register reset values
    localparam logic [CODE_W-1:0]  SHOWN_CODE_RST  = 8'd0;
    localparam logic [TICKS_W-1:0] HALF_PERIOD_RST = 16'd200;
    localparam logic [TICKS_W-1:0] DIGIT_GAP_RST   = 16'd500;
    localparam logic [TICKS_W-1:0] REPEAT_GAP_RST  = 16'd1000;

    // Reciprocal of ten: (x * 205) >> 11 is exact for x below 1029
    localparam logic [CODE_W-1:0] RECIP_TEN  = 8'd205;
    localparam int                RECIP_SHIFT = 11;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SHOWN_CODE  = 2'd0,
        CFG_HALF_PERIOD = 2'd1,
        CFG_DIGIT_GAP   = 2'd2,
        CFG_REPEAT_GAP  = 2'd3
    } cfg_idx_t;

    // Sequence phases
    typedef enum logic [1:0] {
        PH_TENS   = 2'd0,
        PH_DGAP   = 2'd1,
        PH_UNITS  = 2'd2,
        PH_RGAP   = 2'd3
    } phase_t;

    // Code split into decimal digits
    typedef struct packed {
        logic [TENS_W-1:0]  tens;
        logic [UNITS_W-1:0] units;
    } digits_t;

    // One result item
    typedef struct packed {
        phase_t phase;
        logic   green;
        logic   blue;
    } result_t;

endpackage

`default_nettype wire

[rtl/ecbs_digit_split.sv]
// ----------------------------------------------------------------------------
// ecbs_digit_split
// Splits the shown code into tens and units by a reciprocal multiply.
// ----------------------------------------------------------------------------
`default_nettype none

module ecbs_digit_split
    import ecbs_pkg::*;
(
    input  wire logic [CODE_W-1:0] code,
    output digits_t                digits
);

    logic [2*CODE_W-1:0] prod;
    logic [TENS_W-1:0]   tens;
    logic [CODE_W-1:0]   tens_x10;

    // Estimate tens by multiply and shift
    assign prod = code * RECIP_TEN;
    assign tens = prod[RECIP_SHIFT +: TENS_W];

    // Units are what the tens leave over
    assign tens_x10 = {tens, 3'b000} + {2'b00, tens, 1'b0};
    assign digits.tens  = tens;
    assign digits.units = UNITS_W'(code - tens_x10);

endmodule

`default_nettype wire

[rtl/ecbs_seq_core.sv]
// ----------------------------------------------------------------------------
// ecbs_seq_core
// Blink sequencer state and its one-tick update.
// ----------------------------------------------------------------------------
`default_nettype none

module ecbs_seq_core
    import ecbs_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               step,
    input  wire logic               tick,
    input  wire digits_t            digits,
    input  wire logic [TICKS_W-1:0] half_period,
    input  wire logic [TICKS_W-1:0] digit_gap,
    input  wire logic [TICKS_W-1:0] repeat_gap,
    output result_t                 res
);

    phase_t              phase_reg, phase_next;
    logic                half_reg, half_next;
    logic [TICKS_W-1:0]  count_reg, count_next;
    logic [BLINKS_W-1:0] done_reg, done_next;
    logic                blue_reg, blue_next;
    logic                green_reg, green_next;

    phase_t              spent;
    logic [BLINKS_W-1:0] digit;
    logic [BLINKS_W-1:0] done_inc;
    logic [TICKS_W-1:0]  count_inc;
    logic [TICKS_W-1:0]  limit;
    logic [TICKS_W-1:0]  gap_sel;

    // Compute the state after one tick
    always_comb
    begin
        phase_next = phase_reg;
        half_next  = half_reg;
        count_next = count_reg;
        done_next  = done_reg;
        blue_next  = blue_reg;
        green_next = green_reg;

        // Leave a blink phase whose digit is already used up
        digit = (phase_reg == PH_TENS) ? digits.tens : BLINKS_W'(digits.units);
        if ((phase_reg == PH_TENS || phase_reg == PH_UNITS) && done_reg >= digit)
        begin
            if (phase_reg == PH_TENS)
                blue_next = 1'b1;
            else
                green_next = 1'b1;
            phase_next = phase_t'(phase_reg + 2'd1);
            half_next  = 1'b0;
            count_next = '0;
            done_next  = '0;
        end
        spent = phase_next;

        digit     = (phase_next == PH_TENS) ? digits.tens : BLINKS_W'(digits.units);
        count_inc = count_next + TICKS_W'(1);
        done_inc  = done_next + BLINKS_W'(1);
        gap_sel   = (phase_next == PH_DGAP) ? digit_gap : repeat_gap;

        if (phase_next == PH_TENS || phase_next == PH_UNITS)
        begin
            // Drive the blinking LED and count its half period
            if (phase_next == PH_TENS)
                blue_next = half_next;
            else
                green_next = half_next;
            limit = (half_period == '0) ? TICKS_W'(1) : half_period;
            if (count_inc >= limit)
            begin
                count_next = '0;
                if (!half_next)
                begin
                    half_next = 1'b1;
                end
                else
                begin
                    half_next = 1'b0;
                    if (done_inc >= digit)
                    begin
                        phase_next = phase_t'(phase_next + 2'd1);
                        done_next  = '0;
                    end
                    else
                    begin
                        done_next = done_inc;
                    end
                end
            end
            else
            begin
                count_next = count_inc;
            end
        end
        else
        begin
            // Count the gap
            limit = (gap_sel == '0) ? TICKS_W'(1) : gap_sel;
            if (count_inc >= limit)
            begin
                count_next = '0;
                half_next  = 1'b0;
                done_next  = '0;
                phase_next = phase_t'(phase_next + 2'd1);
            end
            else
            begin
                count_next = count_inc;
            end
        end
    end

    // Report the levels after the tick, or hold the current ones
    always_comb
    begin
        if (tick)
        begin
            res.blue  = blue_next;
            res.green = green_next;
            res.phase = spent;
        end
        else
        begin
            res.blue  = blue_reg;
            res.green = green_reg;
            res.phase = phase_reg;
        end
    end

    // Advance the state on each tick request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_TENS;
            half_reg  <= 1'b0;
            count_reg <= '0;
            done_reg  <= '0;
            blue_reg  <= 1'b1;
            green_reg <= 1'b1;
        end
        else if (step && tick)
        begin
            phase_reg <= phase_next;
            half_reg  <= half_next;
            count_reg <= count_next;
            done_reg  <= done_next;
            blue_reg  <= blue_next;
            green_reg <= green_next;
        end
    end

endmodule

`default_nettype wire

[rtl/error_code_blink_sequencer_unit.sv]
// Flow: an accepted request waits in the input register; its result is then
// registered and offered. Throughput: one request per cycle while results are
// taken; both registers advance whenever the stage after them can take data.
// Reset: both LEDs at level 1, sequence at the start of the tens blinks,
// configuration registers at code 0, half period 200, gaps 500 and 1000.
// ----------------------------------------------------------------------------
// error_code_blink_sequencer_unit
// Shows a configured error code as blue tens blinks and green units blinks.
// ----------------------------------------------------------------------------
`default_nettype none

module error_code_blink_sequencer_unit
    import ecbs_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [TDATA_W-1:0]   s_axis_tdata,   // [0] tick
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [TDATA_W-1:0]        m_axis_tdata,   // [0] blue_level, [1] green_level,
                                                      // [3:2] sequence_phase
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [TICKS_W-1:0]   cfg_wr_data
);

    logic [CODE_W-1:0]  code_reg;
    logic [TICKS_W-1:0] half_reg;
    logic [TICKS_W-1:0] dgap_reg;
    logic [TICKS_W-1:0] rgap_reg;

    logic    in_valid_reg, in_valid_next;
    logic    tick_reg;
    logic    out_valid_reg, out_valid_next;
    result_t out_reg;

    logic    out_ready;
    logic    advance;
    digits_t digits;
    result_t res;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_reg <= SHOWN_CODE_RST;
            half_reg <= HALF_PERIOD_RST;
            dgap_reg <= DIGIT_GAP_RST;
            rgap_reg <= REPEAT_GAP_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_SHOWN_CODE:  code_reg <= cfg_wr_data[CODE_W-1:0];
                CFG_HALF_PERIOD: half_reg <= cfg_wr_data;
                CFG_DIGIT_GAP:   dgap_reg <= cfg_wr_data;
                CFG_REPEAT_GAP:  rgap_reg <= cfg_wr_data;
                default:         ;
            endcase
        end
    end

    // Handshake between input register and result register
    assign out_ready     = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && out_ready;
    assign s_axis_tready = !in_valid_reg || out_ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_axis_tvalid && s_axis_tready)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the tick request
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
            tick_reg <= s_axis_tdata[0];
    end

    ecbs_digit_split u_digit_split (
        .code   (code_reg),
        .digits (digits)
    );

    ecbs_seq_core u_seq_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .tick        (tick_reg),
        .digits      (digits),
        .half_period (half_reg),
        .digit_gap   (dgap_reg),
        .repeat_gap  (rgap_reg),
        .res         (res)
    );

    // Hold the result until taken
    always_ff @(posedge clk)
    begin
        if (advance)
            out_reg <= res;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(TDATA_W-4){1'b0}}, out_reg.phase, out_reg.green, out_reg.blue};

endmodule

`default_nettype wire

[tb/error_code_blink_checker.sv]
// ----------------------------------------------------------------------------
// error_code_blink_checker
// Watches the request, result and register channels of the blink sequencer,
// predicts the LED levels and phase of every accepted tick request and checks
// each accepted result against the oldest prediction.
// ----------------------------------------------------------------------------
module error_code_blink_checker
    import ecbs_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_axis_tvalid,
    input  wire logic                 s_axis_tready,
    input  wire logic [TDATA_W-1:0]   s_axis_tdata,   // [0] tick
    input  wire logic                 m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    input  wire logic [TDATA_W-1:0]   m_axis_tdata,   // [0] blue_level, [1] green_level,
                                                      // [3:2] sequence_phase
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [TICKS_W-1:0]   cfg_wr_data,
    output int                        mismatches,
    output int                        pending_results
);

    // Shadow copy of the configuration registers
    logic [CODE_W-1:0]  code_reg;
    logic [TICKS_W-1:0] half_reg;
    logic [TICKS_W-1:0] digit_gap_reg;
    logic [TICKS_W-1:0] repeat_gap_reg;

    // Predicted sequencer state
    phase_t             cur_phase;
    logic               in_high_half;
    logic [TICKS_W-1:0] tick_count;
    logic [BLINKS_W-1:0] blinks_shown;
    logic               blue_pin;
    logic               green_pin;

    result_t            led_expect_q[$];
    result_t            seen;
    result_t            want;
    result_t            fresh;

    // Count one mismatch; keep the log short on a badly broken design
    task report_mismatch(input string what, input int got, input int exp_val);
        mismatches = mismatches + 1;
        if (mismatches <= 40)
            $display("[%0t] %s: got %0d, want %0d", $realtime, what, got, exp_val);
    endtask

    // A programmed count of zero behaves as one tick
    function automatic logic [TICKS_W-1:0] eff_ticks(input logic [TICKS_W-1:0] v);
        return (v == '0) ? TICKS_W'(1) : v;
    endfunction

    // Digit shown by the current blink phase
    function automatic logic [TENS_W-1:0] current_digit();
        if (cur_phase == PH_TENS)
            return TENS_W'(code_reg / 8'd10);
        return TENS_W'(code_reg % 8'd10);
    endfunction

    // Drive the LED that belongs to the current blink phase
    task drive_phase_led(input logic level);
        if (cur_phase == PH_TENS)
            blue_pin = level;
        else
            green_pin = level;
    endtask

    // Advance the blink pattern by one request and return the LED result
    task advance_blink_pattern(input logic tick, output result_t res);
        phase_t             spent;
        logic [TICKS_W-1:0] limit;
        spent = cur_phase;
        if (tick)
        begin
            // Leave a blink phase whose digit is already shown (zero digit too)
            if ((cur_phase == PH_TENS || cur_phase == PH_UNITS) &&
                blinks_shown >= current_digit())
            begin
                drive_phase_led(1'b1);
                cur_phase    = cur_phase.next();
                in_high_half = 1'b0;
                tick_count   = '0;
                blinks_shown = '0;
            end
            spent = cur_phase;

            if (cur_phase == PH_TENS || cur_phase == PH_UNITS)
            begin
                drive_phase_led(in_high_half);
                tick_count = tick_count + 1'b1;
                if (tick_count >= eff_ticks(half_reg))
                begin
                    tick_count = '0;
                    if (!in_high_half)
                    begin
                        in_high_half = 1'b1;
                    end
                    else
                    begin
                        in_high_half = 1'b0;
                        blinks_shown = blinks_shown + 1'b1;
                        if (blinks_shown >= current_digit())
                        begin
                            cur_phase    = cur_phase.next();
                            blinks_shown = '0;
                        end
                    end
                end
            end
            else
            begin
                limit = eff_ticks((cur_phase == PH_DGAP) ? digit_gap_reg : repeat_gap_reg);
                tick_count = tick_count + 1'b1;
                if (tick_count >= limit)
                begin
                    tick_count   = '0;
                    in_high_half = 1'b0;
                    blinks_shown = '0;
                    cur_phase    = cur_phase.next();
                end
            end
        end
        res.blue  = blue_pin;
        res.green = green_pin;
        res.phase = spent;
    endtask

    // Check results, predict requests, follow register writes
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_reg        = SHOWN_CODE_RST;
            half_reg        = HALF_PERIOD_RST;
            digit_gap_reg   = DIGIT_GAP_RST;
            repeat_gap_reg  = REPEAT_GAP_RST;
            cur_phase       = PH_TENS;
            in_high_half    = 1'b0;
            tick_count      = '0;
            blinks_shown    = '0;
            blue_pin        = 1'b1;
            green_pin       = 1'b1;
            led_expect_q.delete();
            pending_results <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                seen = m_axis_tdata[3:0];
                if (led_expect_q.size() == 0)
                begin
                    report_mismatch("result with no request pending", seen, -1);
                end
                else
                begin
                    want = led_expect_q.pop_front();
                    if (seen.blue !== want.blue)
                        report_mismatch("blue_level", seen.blue, want.blue);
                    if (seen.green !== want.green)
                        report_mismatch("green_level", seen.green, want.green);
                    if (seen.phase !== want.phase)
                        report_mismatch("sequence_phase", seen.phase, want.phase);
                end
            end

            if (s_axis_tvalid && s_axis_tready)
            begin
                advance_blink_pattern(s_axis_tdata[0], fresh);
                led_expect_q.push_back(fresh);
            end

            if (cfg_wr_en)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_SHOWN_CODE:  code_reg       = cfg_wr_data[CODE_W-1:0];
                    CFG_HALF_PERIOD: half_reg       = cfg_wr_data;
                    CFG_DIGIT_GAP:   digit_gap_reg  = cfg_wr_data;
                    CFG_REPEAT_GAP:  repeat_gap_reg = cfg_wr_data;
                    default:         ;
                endcase
            end

            pending_results <= led_expect_q.size();
        end
    end

endmodule

[tb/tb_error_code_blink_sequencer_unit.sv]
// ----------------------------------------------------------------------------
// tb_error_code_blink_sequencer_unit
// Drives tick requests and register settings into the blink sequencer under
// several idle and stall patterns, with one long result hold-off, and reports
// the verdict from the checker's mismatch and pending result counts.
// ----------------------------------------------------------------------------
module tb_error_code_blink_sequencer_unit;
    import ecbs_pkg::*;

    localparam int QUIET_LIMIT  = 3000;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_COUNT  = 14;
    localparam int PHASE_ITEMS  = 125;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    wire logic            s_axis_tready;
    logic [TDATA_W-1:0]   s_axis_tdata = '0;   // [0] tick
    wire logic            m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    wire logic [TDATA_W-1:0] m_axis_tdata;     // [0] blue_level, [1] green_level,
                                               // [3:2] sequence_phase
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_SHOWN_CODE;
    logic [TICKS_W-1:0]   cfg_wr_data = '0;

    int                   mismatches;
    int                   pending_results;
    int                   idle_pct = 0;
    int                   stall_pct = 0;
    logic                 pressure_go = 1'b0;
    logic                 rx_hold = 1'b0;
    int                   quiet_cycles = 0;

    error_code_blink_sequencer_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wr_data   (cfg_wr_data)
    );

    error_code_blink_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wr_data     (cfg_wr_data),
        .mismatches      (mismatches),
        .pending_results (pending_results)
    );

    // Generate the clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // Stall the result side at random, or hold it off entirely on request
    always @(posedge clk)
    begin
        if (rx_hold)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Hold off results for a long stretch once, so the block backs up
    initial
    begin
        wait (pressure_go);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    // End the run when nothing moves for too long
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("error_code_blink_sequencer_unit: mismatch");
            $finish;
        end
    end

    // Offer one tick request, with random idle cycles ahead of it
    task offer_tick(input logic tick);
        while ($urandom_range(99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(TDATA_W-1){1'b0}}, tick};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
    endtask

    // Drop valid and wait until every predicted result has come back
    task drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0) @(posedge clk);
    endtask

    // Write one register; the caller drops the write enable afterwards
    task put_reg(input cfg_idx_t idx, input logic [TICKS_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= value;
        @(posedge clk);
    endtask

    // Program all four registers back to back
    task load_settings(input logic [CODE_W-1:0] code, input logic [TICKS_W-1:0] half,
                       input logic [TICKS_W-1:0] dgap, input logic [TICKS_W-1:0] rgap);
        put_reg(CFG_SHOWN_CODE, TICKS_W'(code));
        put_reg(CFG_HALF_PERIOD, half);
        put_reg(CFG_DIGIT_GAP, dgap);
        put_reg(CFG_REPEAT_GAP, rgap);
        cfg_wr_en <= 1'b0;
    endtask

    // Pick a tick count: mostly short, sometimes zero or the maximum
    function automatic logic [TICKS_W-1:0] pick_ticks();
        int roll;
        roll = $urandom_range(99);
        if (roll < 55)
            return TICKS_W'($urandom_range(4, 1));
        else if (roll < 65)
            return '0;
        else if (roll < 75)
            return '1;
        return TICKS_W'($urandom_range(40, 5));
    endfunction

    // Stimulus and verdict
    initial
    begin
        int                ph;
        int                n;
        int                roll;
        logic [CODE_W-1:0] code_pick;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: code zero skips the tens blinks, holds in between
        offer_tick(1'b0);
        offer_tick(1'b1);
        offer_tick(1'b1);
        offer_tick(1'b0);
        drain_results();

        // Zero period and gaps act as one tick; one blink on each LED
        load_settings(8'd11, '0, '0, '0);
        for (n = 0; n < 16; n++)
            offer_tick(n != 5 && n != 11);
        drain_results();

        for (ph = 0; ph < PHASE_COUNT; ph++)
        begin
            // Rotate through the idle and stall patterns
            case (ph % 4)
                0:       begin idle_pct = 0;  stall_pct <= 0;  end
                1:       begin idle_pct = 46; stall_pct <= 0;  end
                2:       begin idle_pct = 0;  stall_pct <= 46; end
                default: begin idle_pct = 6;  stall_pct <= 6;  end
            endcase

            if (ph == 0)
            begin
                // Longest counts with the largest code
                load_settings(8'd255, '1, '1, '1);
            end
            else if (ph == 1)
            begin
                // Lower the counts mid-count; all 25 tens blinks fit in the phase
                load_settings(8'd255, 16'd1, 16'd2, 16'd3);
            end
            else
            begin
                roll = $urandom_range(99);
                if (roll < 30)
                begin
                    case ($urandom_range(4))
                        0:       code_pick = 8'd0;
                        1:       code_pick = 8'd9;
                        2:       code_pick = 8'd10;
                        3:       code_pick = 8'd99;
                        default: code_pick = 8'd255;
                    endcase
                end
                else
                begin
                    code_pick = CODE_W'($urandom_range(255));
                end
                load_settings(code_pick, pick_ticks(), pick_ticks(), pick_ticks());
            end

            if (ph == 4)
                pressure_go <= 1'b1;

            for (n = 0; n < PHASE_ITEMS; n++)
                offer_tick($urandom_range(99) < 85);
            drain_results();
        end

        repeat (8) @(posedge clk);
        if (mismatches == 0 && pending_results == 0)
            $display("error_code_blink_sequencer_unit: match");
        else
            $display("error_code_blink_sequencer_unit: mismatch");
        $finish;
    end

endmodule
